/* rtl/md5_name_uuid_v3_assert.svh */
// Assertion macros for the name-based UUID block
`ifndef MD5_NAME_UUID_V3_ASSERT_SVH
`define MD5_NAME_UUID_V3_ASSERT_SVH
// Check that an implication holds at every clock edge outside reset
`define MNU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds at a clock edge outside reset
`define MNU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* rtl/mnu_pkg.sv */
// ----------------------------------------------------------------------------
// mnu_pkg
// Constants, types and round tables for the name-based UUID (MD5) block.
// ----------------------------------------------------------------------------
package mnu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BufDepth = 16;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [63:0] VerMask = 64'hFFFFFFFFFFFF0FFF;
  localparam logic [63:0] VerSet  = 64'h0000000000003000;
  localparam logic [63:0] VarMask = 64'h3FFFFFFFFFFFFFFF;
  localparam logic [63:0] VarSet  = 64'h8000000000000000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } out_item_t;

  // Control handed from the sequencer to the compression core
  typedef struct packed {
    logic       start;
    logic [5:0] round;
    logic       active;
  } core_ctl_t;

  function automatic logic [31:0] round_add(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by a round
  function automatic logic [3:0] word_index(input logic [5:0] r);
    logic [3:0] w;
    case (r[5:4])
      2'd0: w = r[3:0];
      2'd1: w = 4'(5 * r[3:0] + 1);
      2'd2: w = 4'(3 * r[3:0] + 5);
      default: w = 4'(7 * r[3:0]);
    endcase
    return w;
  endfunction

endpackage

/* rtl/mnu_if.sv */
// ----------------------------------------------------------------------------
// mnu_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface mnu_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mnu_ram.sv */
// ----------------------------------------------------------------------------
// mnu_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mnu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/mnu_core.sv */
// ----------------------------------------------------------------------------
// mnu_core
// MD5 round unit: one round per cycle over the chaining words.
// ----------------------------------------------------------------------------
module mnu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mnu_pkg::core_ctl_t  ctl_i,
  input  logic                init_i,
  input  logic [31:0]         word_i,
  output logic                done_o,
  output logic [127:0]        chain_o
);
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] ha_q, hb_q, hc_q, hd_q, ha_d, hb_d, hc_d, hd_d;
  logic [31:0] f, t, rot;
  logic [4:0]  s;
  logic [5:0]  r;
  logic        fin_q;

  assign r = ctl_i.round;
  assign s = mnu_pkg::rot_amount(r);

  always_comb begin
    case (r[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t   = f + a_q + mnu_pkg::round_add(r) + word_i;
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    ha_d = ha_q; hb_d = hb_q; hc_d = hc_q; hd_d = hd_q;
    if (init_i) begin
      ha_d = mnu_pkg::InitA; hb_d = mnu_pkg::InitB;
      hc_d = mnu_pkg::InitC; hd_d = mnu_pkg::InitD;
    end else if (ctl_i.start) begin
      a_d = ha_q; b_d = hb_q; c_d = hc_q; d_d = hd_q;
    end else if (ctl_i.active) begin
      a_d = d_q; d_d = c_q; c_d = b_q; b_d = b_q + rot;
    end else if (fin_q) begin
      ha_d = ha_q + a_q; hb_d = hb_q + b_q; hc_d = hc_q + c_q; hd_d = hd_q + d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q <= mnu_pkg::InitA; hb_q <= mnu_pkg::InitB;
      hc_q <= mnu_pkg::InitC; hd_q <= mnu_pkg::InitD;
      fin_q <= 1'b0;
    end else begin
      ha_q <= ha_d; hb_q <= hb_d; hc_q <= hc_d; hd_q <= hd_d;
      fin_q <= ctl_i.active && (r == 6'd63);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end

  assign done_o  = fin_q;
  // Show the finished chain already in the cycle of the final addition
  assign chain_o = fin_q ? {ha_q + a_q, hb_q + b_q, hc_q + c_q, hd_q + d_q}
                         : {ha_q, hb_q, hc_q, hd_q};
endmodule

/* rtl/md5_name_uuid_v3.sv */
// ----------------------------------------------------------------------------
// md5_name_uuid_v3
// Streams a name one byte per item through MD5 and emits a version 3 UUID.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_i    | in  | data_byte[7:0], has_byte, last_byte
// out_o   | out | uuid_high[63:0], uuid_low[63:0]
//
// Byte items are taken one per cycle while idle; the 64th byte of a block
// starts compression (one MD5 round per cycle, word reads from the block RAM).
// A last item pads byte by byte (up to 72 pad bytes), compressing one or two
// blocks, then loads the result register. Reset restores the MD5 initial
// chain; the block RAM needs no clearing. Input stalls while busy; the result
// register holds until taken and the next item may enter meanwhile. A UUID
// that finishes while the previous one still waits holds in the final state.
// ----------------------------------------------------------------------------
`include "md5_name_uuid_v3_assert.svh"

module md5_name_uuid_v3 (
  input logic clk_i,
  input logic rst_ni,
  mnu_if.sink   in_i,
  mnu_if.source out_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPad  = 5'b00010,
    StLoad = 5'b00100,
    StRun  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  logic [1:0]  len_q, len_d;
  logic        padding_q, padding_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] word_q, word_d;
  logic        wr_en, acc, init;
  logic [3:0]  raddr;
  logic [31:0] rdata, wdata;
  logic [7:0]  byte_v, pad_v;
  logic        put;
  logic        done;
  logic [127:0] chain;
  mnu_pkg::core_ctl_t ctl;
  mnu_pkg::out_item_t res_q, res_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] hi, lo;

  assign in_i.ready = (st_q == StIdle) && !padding_q;
  assign acc = in_i.valid && in_i.ready;

  // Pad byte for current position: marker, zeros, then the bit length
  always_comb begin
    pad_v = 8'h00;
    if (len_q[1]) pad_v = mnu_pkg::PadByte;
    else if (len_q[0] && pos_q >= 6'd56) pad_v = 8'(bits_q >> {pos_q[2:0], 3'b000});
  end

  // Byte assembly register for the current word (writes whole words)
  always_comb begin
    put    = 1'b0;
    byte_v = 8'h00;
    if (acc && in_i.data.has_byte) begin put = 1'b1; byte_v = in_i.data.data_byte; end
    if (st_q == StPad) begin put = 1'b1; byte_v = pad_v; end
    word_d = word_q;
    case (pos_q[1:0])
      2'd0: word_d = {24'h0, byte_v};
      2'd1: word_d[15:8] = byte_v;
      2'd2: word_d[23:16] = byte_v;
      default: word_d[31:24] = byte_v;
    endcase
    if (!put) word_d = word_q;
    wdata = word_d;
    wr_en = put;
  end

  always_comb begin
    st_d = st_q; pos_d = pos_q; bits_d = bits_q; len_d = len_q;
    padding_d = padding_q; rnd_d = rnd_q; init = 1'b0;
    ctl = '0; raddr = mnu_pkg::word_index(rnd_q);
    res_d = res_q; ovalid_d = ovalid_q;
    hi = '0; lo = '0;
    if (out_o.ready) ovalid_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (padding_q && !ovalid_q) begin
          st_d = StPad;
          len_d = 2'b10;
        end else if (acc) begin
          if (in_i.data.has_byte) begin
            pos_d = pos_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (pos_q == 6'd63) begin st_d = StLoad; rnd_d = '0; end
          end
          if (in_i.data.last_byte) begin
            padding_d = 1'b1;
            len_d = 2'b10;
            if (!(in_i.data.has_byte && pos_q == 6'd63)) st_d = StPad;
          end
        end
      end
      StPad: begin
        pos_d = pos_q + 6'd1;
        len_d[1] = 1'b0;
        // Length goes in this block once slot 55 is filled
        if (pos_q == 6'd55) len_d[0] = 1'b1;
        if (pos_q == 6'd63) begin st_d = StLoad; rnd_d = '0; end
      end
      StLoad: begin
        ctl.start = 1'b1;
        st_d = StRun;
        rnd_d = 6'd1;
      end
      StRun: begin
        ctl.active = 1'b1;
        ctl.round = rnd_q - 6'd1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd0) st_d = StFin;
      end
      StFin: begin
        if (padding_q && len_q[0]) begin
          // Hold until the result register is free
          if (!ovalid_q || out_o.ready) begin
            st_d = StIdle;
            padding_d = 1'b0;
            hi = {chain[103:96], chain[111:104], chain[119:112], chain[127:120],
                  chain[71:64], chain[79:72], chain[87:80], chain[95:88]};
            lo = {chain[39:32], chain[47:40], chain[55:48], chain[63:56],
                  chain[7:0], chain[15:8], chain[23:16], chain[31:24]};
            res_d.uuid_high = (hi & mnu_pkg::VerMask) | mnu_pkg::VerSet;
            res_d.uuid_low  = (lo & mnu_pkg::VarMask) | mnu_pkg::VarSet;
            ovalid_d = 1'b1;
            init = 1'b1;
            bits_d = '0;
            len_d = '0;
          end
        end else if (padding_q) begin
          // Continue padding in a fresh block
          st_d = StPad;
        end else begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StRun) raddr = mnu_pkg::word_index(rnd_q);
    if (st_q == StLoad) raddr = mnu_pkg::word_index(6'd0);
  end

  mnu_ram #(.Width(mnu_pkg::WordW), .Depth(mnu_pkg::BufDepth)) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pos_q[5:2]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mnu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .init_i  (init),
    .word_i  (rdata),
    .done_o  (done),
    .chain_o (chain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pos_q <= '0; bits_q <= '0; len_q <= '0;
      padding_q <= 1'b0; rnd_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; pos_q <= pos_d; bits_q <= bits_d; len_q <= len_d;
      padding_q <= padding_d; rnd_q <= rnd_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    res_q  <= res_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = res_q;

  `MNU_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, (st_q != StIdle) && in_i.ready, "accept while busy")
  `MNU_ASSERT(a_res_stays, clk_i, rst_ni, (out_o.valid && !out_o.ready) |=> out_o.valid, "result dropped")
  `MNU_ASSERT(a_run_len, clk_i, rst_ni, (st_q == StLoad) |=> (st_q == StRun), "load not followed by rounds")
  `MNU_ASSERT(a_fin_done, clk_i, rst_ni, (st_q == StRun && rnd_q == 6'd0) |=> done, "no final add after rounds")
endmodule

/* test/mnu_tb_if.sv */
// ----------------------------------------------------------------------------
// mnu_tb_if
// Test-side channel helpers for the name-based UUID block.
// ----------------------------------------------------------------------------
// The channel interface itself comes with the RTL; this file only holds the
// packing of stimulus rows shared by the testbench.
package mnu_tb_pkg;

  typedef struct {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic        known;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } stim_row_t;
endpackage

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming MD5 version 3 UUID block.
// ----------------------------------------------------------------------------
// Names are fed byte by byte with random gaps on the input and random stalls
// on the output. A behavioral MD5 predictor computes each UUID; results are
// compared in order. A directed table covers the empty name, known digests
// and idle items; block-boundary names and random names of many lengths follow.
// ----------------------------------------------------------------------------
module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mnu_if #(.T(mnu_pkg::in_item_t))  in_ch ();
  mnu_if #(.T(mnu_pkg::out_item_t)) out_ch ();

  md5_name_uuid_v3 uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0] hash_chain [4];
  logic [31:0] msg_words [16];
  logic [5:0]  msg_pos;
  logic [63:0] msg_bits;
  mnu_pkg::out_item_t uuid_queue [$];

  int unsigned mismatches = 0;
  int unsigned uuids_seen = 0;
  int unsigned items_sent = 0;
  bit          quiet_phase = 1'b0;
  bit          long_hold = 1'b0;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int RotS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  task automatic restart_hash();
    hash_chain = '{mnu_pkg::InitA, mnu_pkg::InitB, mnu_pkg::InitC, mnu_pkg::InitD};
    msg_pos = '0;
    msg_bits = '0;
  endtask

  task automatic compress_words();
    logic [31:0] a, b, c, d, f, t;
    int w;
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); w = r;
      end else if (r < 32) begin
        f = (d & b) | (~d & c); w = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; w = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); w = (7 * r) % 16;
      end
      t = f + a + RoundK[r] + msg_words[w];
      a = d; d = c; c = b;
      b = b + ((t << RotS[(r / 16) * 4 + r % 4]) | (t >> (32 - RotS[(r / 16) * 4 + r % 4])));
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
  endtask

  task automatic absorb_byte(input logic [7:0] value);
    msg_words[msg_pos[5:2]][msg_pos[1:0] * 8 +: 8] = value;
    msg_pos = msg_pos + 6'd1;
    if (msg_pos == 6'd0) compress_words();
  endtask

  function automatic logic [63:0] digest_half(input logic [31:0] w0, input logic [31:0] w1);
    return {w0[7:0], w0[15:8], w0[23:16], w0[31:24], w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
  endfunction

  // Advance the predictor by one accepted item; returns 1 with a UUID on last
  task automatic predict_uuid(input mnu_pkg::in_item_t it, output bit got,
                              output mnu_pkg::out_item_t res);
    logic [63:0] nbits;
    got = 1'b0;
    res = '0;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.last_byte) begin
      nbits = msg_bits;
      absorb_byte(mnu_pkg::PadByte);
      while (msg_pos != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(nbits[8 * i +: 8]);
      res.uuid_high = (digest_half(hash_chain[0], hash_chain[1]) & mnu_pkg::VerMask) |
                      mnu_pkg::VerSet;
      res.uuid_low  = (digest_half(hash_chain[2], hash_chain[3]) & mnu_pkg::VarMask) |
                      mnu_pkg::VarSet;
      got = 1'b1;
      restart_hash();
    end
  endtask

  // Directed table
  mnu_tb_pkg::stim_row_t table_rows [$];

  task automatic add_row(input logic [7:0] db, input logic hb, input logic lb);
    table_rows.push_back('{db, hb, lb, 1'b0, 64'h0, 64'h0});
  endtask

  task automatic add_known(input logic [7:0] db, input logic hb, input logic lb,
                           input logic [63:0] hi, input logic [63:0] lo);
    table_rows.push_back('{db, hb, lb, 1'b1, hi, lo});
  endtask

  task automatic report(input string what, input mnu_pkg::out_item_t exp_v,
                        input mnu_pkg::out_item_t act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: %s mismatch exp %h_%h got %h_%h", what, exp_v.uuid_high, exp_v.uuid_low,
               act_v.uuid_high, act_v.uuid_low);
  endtask

  // Send one item with optional random gap
  task automatic send_item(input mnu_pkg::in_item_t it);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      in_ch.data  <= mnu_pkg::in_item_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_name(input int len);
    mnu_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      it.has_byte = 1'b1;
      it.last_byte = (i == len - 1);
      send_item(it);
    end
    if (len == 0) begin
      it = '{8'($urandom), 1'b0, 1'b1};
      send_item(it);
    end
  endtask

  // Stimulus
  initial begin
    mnu_pkg::in_item_t it;
    int len;
    int bound_lens [6];
    bound_lens = '{55, 56, 63, 64, 65, 128};
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    restart_hash();
    foreach (msg_words[i]) msg_words[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty name, idle item, single bytes at the extremes
    add_known(8'h00, 1'b0, 1'b1, 64'hd41d8cd98f003204, 64'ha9800998ecf8427e);
    add_row(8'hff, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b1);
    add_row(8'hff, 1'b1, 1'b1);
    // "abc" with an idle item in the middle
    add_row(8'h61, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h62, 1'b1, 1'b0);
    add_known(8'h63, 1'b1, 1'b1, 64'h900150983cd23fb0, 64'h96963f7d28e17f72);
    // last byte alone closes a one-byte name after a byte item
    add_row(8'h5a, 1'b1, 1'b0);
    add_row(8'ha5, 1'b0, 1'b1);
    foreach (table_rows[i]) begin
      it = '{table_rows[i].data_byte, table_rows[i].has_byte, table_rows[i].last_byte};
      send_item(it);
    end
    // block boundaries: 55, 56, 63, 64, 65 bytes; 128 bytes
    foreach (bound_lens[k]) send_name(bound_lens[k]);

    // output held off long while input keeps offering short names
    long_hold = 1'b1;
    repeat (6) send_name(2);
    long_hold = 1'b0;
    // pause until drained
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (uuid_queue.size() != 0) @(posedge clk_i);

    while (items_sent < 600) begin
      if (items_sent > 500) quiet_phase = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          it = '{8'($urandom), 1'b0, 1'($urandom_range(0, 1))};
          send_item(it);
        end
        1: begin
          len = $urandom_range(50, 140);
          send_name(len);
        end
        default: begin
          len = $urandom_range(0, 12);
          send_name(len);
        end
      endcase
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (uuid_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("tb: %0d items sent, %0d UUIDs checked (empty, short, multi-block names)",
             items_sent, uuids_seen);
    if (mismatches == 0 && uuid_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Predict at each accepted item
  int row_idx = 0;
  always @(posedge clk_i) begin
    bit got;
    mnu_pkg::out_item_t res;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_uuid(in_ch.data, got, res);
      if (row_idx < table_rows.size()) begin
        if (got && table_rows[row_idx].known &&
            (res.uuid_high != table_rows[row_idx].uuid_high ||
             res.uuid_low != table_rows[row_idx].uuid_low))
          report("table", '{table_rows[row_idx].uuid_high, table_rows[row_idx].uuid_low}, res);
        row_idx++;
      end
      if (got) uuid_queue.push_back(res);
    end
  end

  // Receiver: random stalls, one long hold
  int hold_left = 0;
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold && hold_left == 0) begin
        out_ch.ready <= 1'b0;
        hold_left = 400;
        while (hold_left > 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        hold_left = -1;
      end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      if (!long_hold && hold_left < 0) hold_left = 0;
    end
  end

  // Check results
  always @(posedge clk_i) begin
    mnu_pkg::out_item_t exp_v;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      uuids_seen++;
      if (uuid_queue.size() == 0) begin
        report("unexpected", '0, out_ch.data);
      end else begin
        exp_v = uuid_queue.pop_front();
        if (exp_v.uuid_high !== out_ch.data.uuid_high) report("uuid_high", exp_v, out_ch.data);
        else if (exp_v.uuid_low !== out_ch.data.uuid_low) report("uuid_low", exp_v, out_ch.data);
      end
    end
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end
endmodule
